// ----- design/ehl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ehl_pkg;

  localparam int unsigned BufferBytesDef = 4096;
  localparam int unsigned MaxHdr         = 10;
  localparam int unsigned LebW           = 35;
  localparam int unsigned TotW           = 17;
  localparam int unsigned SumW           = 18;
  localparam int unsigned IndexReset     = 8;

  localparam logic [31:0] LowMask  = 32'h0000_1fff;
  localparam logic [31:0] HighMask = 32'hffff_e000;

  typedef enum logic [2:0] {
    ST_APPEND   = 3'd0,
    ST_REPEAT   = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_TOO_BIG  = 3'd3,
    ST_ROLLOVER = 3'd4
  } ehl_status_e;

  typedef struct packed {
    logic [31:0] expected_index;
    logic [15:0] event_code;
    logic [15:0] payload_size;
    logic [31:0] timestamp;
    logic        coarse_time;
    logic        skip_repeat;
  } ehl_in_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic        has_byte;
    logic [2:0]  status;
    logic [31:0] index_after;
    logic        run_end;
  } ehl_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic decide;
    logic emit;
  } ehl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_ready;
    logic last;
  } ehl_sts_t;

  // number of leb128 bytes for a value
  function automatic logic [2:0] leb_len(input logic [LebW-1:0] v);
    logic [2:0] n;
    n = 3'd1;
    if (|v[LebW-1:7])  n = 3'd2;
    if (|v[LebW-1:14]) n = 3'd3;
    if (|v[LebW-1:21]) n = 3'd4;
    if (|v[LebW-1:28]) n = 3'd5;
    return n;
  endfunction

  // one leb128 byte: 7 data bits and the continuation bit
  function automatic logic [7:0] leb_byte(input logic [LebW-1:0] v, input logic [3:0] idx,
                                          input logic [2:0] len);
    logic [LebW-1:0] sh;
    logic            cont;
    sh   = v >> (7 * idx);
    cont = ({1'b0, idx} + 5'd1) < {2'b00, len};
    return {cont, sh[6:0]};
  endfunction

endpackage

`default_nettype wire

// ----- design/ehl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ehl_ctrl
  import ehl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire ehl_sts_t sts_i,
  output ehl_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_EMIT   = 4'b1000
  } ehl_state_e;

  ehl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_capture_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == S_CALC)
    else $error("capture not followed by calc");

  a_emit_only_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == S_EMIT) && sts_i.out_ready)
    else $error("emit outside emit state");

  a_state_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

endmodule

`default_nettype wire

// ----- design/ehl_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ehl_datapath
  import ehl_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BufferBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ehl_cmd_t    cmd_i,
  output ehl_sts_t         sts_o,
  input  wire ehl_in_t     in_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ehl_out_t         out_data_o
);

  localparam int unsigned SizeW = $clog2(BUFFER_BYTES - 7);
  localparam int unsigned FillW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned CntW  = $clog2(MaxHdr + 1);

  // buffer state
  logic [15:0]      prev_code_q;
  logic [SizeW-1:0] prev_size_q;
  logic [31:0]      prev_stamp_q;
  logic [FillW-1:0] fill_q;
  logic [31:0]      index_q;

  // captured item and calc results
  ehl_in_t          item_q;
  logic [31:0]      time_q, time_d;
  logic [LebW-1:0]  v0_q, v0_d, v1_q, v1_d, v2_q, v2_d;
  logic [2:0]       len0_q, len1_q, len2_q;
  logic             same_q, same_d;

  // emit state
  logic [7:0]       hdr_q [MaxHdr];
  logic [7:0]       hdr_d [MaxHdr];
  logic [CntW-1:0]  cnt_q;
  logic [2:0]       st_q, st_d;
  logic             has_q;

  logic             out_valid_q;
  ehl_out_t         out_q;

  // calc stage: coarsen time, delta, leb128 value words
  logic [31:0] delta;
  logic        trunc;

  always_comb begin
    time_d = item_q.timestamp;
    if (item_q.coarse_time && (((prev_stamp_q & LowMask) == '0) ||
        ((prev_stamp_q & HighMask) != (item_q.timestamp & HighMask)))) begin
      time_d = item_q.timestamp & HighMask;
    end
    delta  = time_d - prev_stamp_q;
    trunc  = ((delta & LowMask) == '0);
    same_d = (item_q.event_code == prev_code_q) &&
             (item_q.payload_size == 16'(prev_size_q));
    if (same_d) begin
      // short form: time only
      v0_d = trunc ? {14'd0, delta[31:13], 2'b10} : {1'b0, delta, 2'b00};
      v1_d = '0;
      v2_d = '0;
    end else begin
      v0_d = {17'd0, item_q.event_code, trunc, 1'b1};
      v1_d = {19'd0, item_q.payload_size};
      v2_d = trunc ? {16'd0, delta[31:13]} : {3'd0, delta};
    end
  end

  // decide stage
  logic [3:0]      n_hdr;
  logic [TotW-1:0] total;
  logic [SumW-1:0] fill_sum;
  logic            mismatch, too_big, full;
  logic [3:0]      k0, k1;

  always_comb begin
    n_hdr    = {1'b0, len0_q} + {1'b0, len1_q} + {1'b0, len2_q};
    total    = TotW'(n_hdr) + TotW'(item_q.payload_size);
    fill_sum = SumW'(fill_q) + SumW'(total);
    mismatch = (item_q.expected_index != index_q);
    too_big  = (n_hdr > 4'(MaxHdr)) || (total > TotW'(BUFFER_BYTES - 8));
    full     = (fill_sum > SumW'(BUFFER_BYTES));
    priority if (mismatch)                      st_d = ST_MISMATCH;
    else if (same_q && item_q.skip_repeat)      st_d = ST_REPEAT;
    else if (too_big)                           st_d = ST_TOO_BIG;
    else if (full)                              st_d = ST_ROLLOVER;
    else                                        st_d = ST_APPEND;
    // place the bytes of the three values one after the other
    for (int k = 0; k < MaxHdr; k++) begin
      k0 = 4'(k) - {1'b0, len0_q};
      k1 = k0 - {1'b0, len1_q};
      if (4'(k) < {1'b0, len0_q})    hdr_d[k] = leb_byte(v0_q, 4'(k), len0_q);
      else if (k0 < {1'b0, len1_q})  hdr_d[k] = leb_byte(v1_q, k0, len1_q);
      else                           hdr_d[k] = leb_byte(v2_q, k1, len2_q);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
    if (cmd_i.calc) begin
      time_q <= time_d;
      v0_q   <= v0_d;
      v1_q   <= v1_d;
      v2_q   <= v2_d;
      len0_q <= leb_len(v0_d);
      len1_q <= same_d ? 3'd0 : leb_len(v1_d);
      len2_q <= same_d ? 3'd0 : leb_len(v2_d);
      same_q <= same_d;
    end
    if (cmd_i.decide) begin
      st_q <= st_d;
      for (int k = 0; k < MaxHdr; k++) begin
        hdr_q[k] <= (st_d == ST_APPEND) ? hdr_d[k] : 8'd0;
      end
    end else if (cmd_i.emit) begin
      for (int k = 0; k < MaxHdr - 1; k++) begin
        hdr_q[k] <= hdr_q[k+1];
      end
      hdr_q[MaxHdr-1] <= 8'd0;
    end
    if (cmd_i.emit) begin
      out_q.header_byte <= hdr_q[0];
      out_q.has_byte    <= has_q;
      out_q.status      <= st_q;
      out_q.index_after <= index_q;
      out_q.run_end     <= (cnt_q == CntW'(1));
    end
  end

  // control and buffer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_code_q  <= '0;
      prev_size_q  <= '0;
      prev_stamp_q <= '0;
      fill_q       <= FillW'(IndexReset);
      index_q      <= '0;
      cnt_q        <= '0;
      has_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // restart the buffer at the recovered index
        index_q      <= cfg_wdata_i;
        fill_q       <= FillW'(IndexReset);
        prev_code_q  <= '0;
        prev_size_q  <= '0;
        prev_stamp_q <= '0;
      end else if (cmd_i.decide) begin
        if (st_d == ST_ROLLOVER) begin
          index_q      <= index_q + 32'd1;
          fill_q       <= FillW'(IndexReset);
          prev_code_q  <= '0;
          prev_size_q  <= '0;
          prev_stamp_q <= '0;
        end else if (st_d == ST_APPEND) begin
          fill_q       <= FillW'(fill_sum);
          prev_code_q  <= item_q.event_code;
          prev_size_q  <= item_q.payload_size[SizeW-1:0];
          prev_stamp_q <= time_q;
        end
      end
      if (cmd_i.decide) begin
        cnt_q <= (st_d == ST_APPEND) ? CntW'(n_hdr) : CntW'(1);
        has_q <= (st_d == ST_APPEND);
      end else if (cmd_i.emit) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.emit)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_ready = !out_valid_q || !out_stall_i;
  assign sts_o.last      = (cnt_q == CntW'(1));
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q >= FillW'(IndexReset)) && (SumW'(fill_q) <= SumW'(BUFFER_BYTES)))
    else $error("fill level out of range");

  a_byte_only_on_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.has_byte |-> out_q.status == ST_APPEND)
    else $error("header byte on a status result");

  a_rollover_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide && !cfg_we_i && (st_d == ST_ROLLOVER)
      |=> (fill_q == FillW'(IndexReset)) && (prev_stamp_q == '0) &&
          (index_q == $past(index_q) + 32'd1))
    else $error("rollover did not restart the buffer");

  a_emit_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> cnt_q != '0)
    else $error("emit with no result left");

endmodule

`default_nettype wire

// ----- design/event_header_leb128_logger.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   in_data_i   (ehl_in_t)
// out      output     out_valid_o / out_stall_i out_data_o  (ehl_out_t)
// cfg      input      cfg_we_i                  cfg_wdata_i (start_index)
//
// an event's results reach the output register through the idle (capture), calc, decide and
// emit states: calc coarsens the time and takes the delta, decide picks the result, and
// emit loads one result per cycle while the output is not stalled; there are 1 to 10
// header bytes, or 1 status result; the input takes the next event once the block is
// back in idle, so the rate is set by the one-byte-per-cycle emit loop
// the next event is taken while the last result still waits in the output register
// a stall on the output holds the emit loop; the input is stalled while an event
// is in flight
// reset clears the buffer state: index 0, fill level 8, last code, size and time 0

module event_header_leb128_logger
  import ehl_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BufferBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // event input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ehl_in_t     in_data_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ehl_out_t         out_data_o,
  // start index register, write only
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  ehl_cmd_t cmd;
  ehl_sts_t sts;

  // sequencer: idle, calc, decide, emit
  ehl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // buffer state, header builder and output register
  ehl_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/event_header_leb128_logger_test.sv -----
`timescale 1ns / 1ps

module event_header_leb128_logger_test;
  import ehl_pkg::*;

  localparam int unsigned BUF_BYTES    = BufferBytesDef;
  localparam int unsigned SETTLE_CYCLS = 16;      // settle time after the drain, block is idle after
  localparam int unsigned HOLD_CYCLS   = 400;     // long output hold-off
  localparam int unsigned CYCLE_LIMIT  = 200_000;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic        in_valid_i  = 1'b0;
  ehl_in_t     in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  // block outputs
  logic     in_stall_o;
  logic     out_valid_o;
  ehl_out_t out_data_o;

  event_header_leb128_logger u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // idle percentages per side, changed between phases
  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 68;

  // one-cycle pulse that starts a long output hold-off
  logic hold_go = 1'b0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // predicted logger state
  // ---------------------------------------------------------------------------
  logic [31:0] buf_index       = '0;
  logic [31:0] fill_bytes      = 32'd8;
  logic [15:0] pred_code       = '0;
  logic [15:0] pred_size       = '0;
  logic [31:0] last_stamp      = '0;

  // header bytes of the event being predicted
  logic [7:0] hdr_bytes[$];

  // results still owed by the block, oldest first
  ehl_out_t header_results_q[$];

  // start index write: also opens a fresh buffer
  function automatic void load_start_index(input logic [31:0] value);
    buf_index       = value;
    fill_bytes      = 32'd8;
    pred_code       = '0;
    pred_size       = '0;
    last_stamp      = '0;
  endfunction

  // unsigned leb128: seven bits per byte, top bit set on all but the last
  function automatic void append_leb(input logic [34:0] value);
    while (value >= 35'h80) begin
      hdr_bytes.push_back({1'b1, value[6:0]});
      value = value >> 7;
    end
    hdr_bytes.push_back({1'b0, value[6:0]});
  endfunction

  // single status transfer, carries the index after the event
  function automatic void push_status(input ehl_status_e st);
    ehl_out_t r;
    r             = '0;
    r.status      = st;
    r.index_after = buf_index;
    r.run_end     = 1'b1;
    header_results_q.push_back(r);
  endfunction

  // works out the transfers one accepted event causes and updates the state
  function automatic void build_event_header(input ehl_in_t ev);
    logic [31:0] stamp;
    logic [31:0] delta;
    logic        trunc;
    int unsigned total;
    ehl_out_t    r;
    hdr_bytes.delete();
    if (ev.expected_index != buf_index) begin
      push_status(ST_MISMATCH);
      return;
    end
    // coarsen only where the stamp cannot step back past the last one
    stamp = ev.timestamp;
    if (ev.coarse_time && ((last_stamp & LowMask) == '0 ||
                           (last_stamp & HighMask) != (stamp & HighMask)))
      stamp = stamp & HighMask;
    delta = stamp - last_stamp;
    trunc = (delta & LowMask) == '0;
    if (ev.event_code == pred_code && ev.payload_size == pred_size) begin
      if (ev.skip_repeat) begin
        push_status(ST_REPEAT);
        return;
      end
      // short form: one value, bit 0 clear
      if (trunc) append_leb({3'b000, (delta >> 11) | 32'd2});
      else append_leb({1'b0, delta, 2'b00});
    end else begin
      // full form: code word, size, then the delta
      append_leb({17'd0, ev.event_code, trunc, 1'b1});
      append_leb({19'd0, ev.payload_size});
      append_leb({3'b000, trunc ? (delta >> 13) : delta});
    end
    total = hdr_bytes.size() + ev.payload_size;
    if (hdr_bytes.size() > MaxHdr || total > BUF_BYTES - 8) begin
      push_status(ST_TOO_BIG);
      return;
    end
    if (fill_bytes + total > BUF_BYTES) begin
      // new buffer, last-event memory cleared
      buf_index  = buf_index + 32'd1;
      fill_bytes = 32'd8;
      pred_code  = '0;
      pred_size  = '0;
      last_stamp = '0;
      push_status(ST_ROLLOVER);
      return;
    end
    fill_bytes = fill_bytes + total;
    pred_code  = ev.event_code;
    pred_size  = ev.payload_size;
    last_stamp = stamp;
    foreach (hdr_bytes[i]) begin
      r             = '0;
      r.header_byte = hdr_bytes[i];
      r.has_byte    = 1'b1;
      r.status      = ST_APPEND;
      r.index_after = buf_index;
      r.run_end     = (i == hdr_bytes.size() - 1);
      header_results_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random stall, long hold-off, result checking
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    ehl_out_t want;
    // a transfer happens at this edge when valid is up and our stall is down
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (header_results_q.size() == 0) begin
        $error("unexpected result transfer: %p", out_data_o);
        error_count++;
      end else begin
        want = header_results_q.pop_front();
        check_field("header_byte", 32'(want.header_byte), 32'(out_data_o.header_byte));
        check_field("has_byte", 32'(want.has_byte), 32'(out_data_o.has_byte));
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("index_after", want.index_after, out_data_o.index_after);
        check_field("run_end", 32'(want.run_end), 32'(out_data_o.run_end));
      end
    end
    if (hold_go) hold_left = HOLD_CYCLS;
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offers one event, waits for its transfer; valid stays up for a following event
  task automatic send_event(input ehl_in_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    build_event_header(ev);
  endtask

  function automatic ehl_in_t make_event(input logic [31:0] idx, input logic [15:0] code,
                                         input logic [15:0] size, input logic [31:0] stamp,
                                         input logic coarse, input logic skip);
    ehl_in_t ev;
    ev.expected_index = idx;
    ev.event_code     = code;
    ev.payload_size   = size;
    ev.timestamp      = stamp;
    ev.coarse_time    = coarse;
    ev.skip_repeat    = skip;
    return ev;
  endfunction

  // mostly well-formed events built on the predicted state, some noise
  function automatic ehl_in_t random_event();
    ehl_in_t     ev;
    int unsigned pick;
    ev.expected_index = buf_index;
    if ($urandom_range(99) < 6) ev.expected_index = $urandom();
    pick = $urandom_range(99);
    if (pick < 35) begin
      // same code and size: short form or a dropped repeat
      ev.event_code   = pred_code;
      ev.payload_size = pred_size;
    end else if (pick < 70) begin
      ev.event_code   = 16'($urandom_range(7));
      ev.payload_size = 16'($urandom_range(64));
    end else if (pick < 92) begin
      ev.event_code   = 16'($urandom_range(65535));
      ev.payload_size = 16'($urandom_range(600));
    end else begin
      // mostly oversized
      ev.event_code   = 16'($urandom_range(65535));
      ev.payload_size = 16'($urandom_range(65535));
    end
    pick = $urandom_range(99);
    if (pick < 40) ev.timestamp = last_stamp + $urandom_range(8191);
    else if (pick < 65) ev.timestamp = last_stamp + ($urandom_range(15) << 13);
    else if (pick < 85) ev.timestamp = last_stamp + $urandom();
    else ev.timestamp = $urandom();
    ev.coarse_time = 1'($urandom_range(1));
    ev.skip_repeat = ($urandom_range(3) == 0);
    return ev;
  endfunction

  // drops valid and waits until every owed result has come, then lets the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (header_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLS) @(posedge clk_i);
  endtask

  // start index write, only with the block idle
  task automatic write_start_index(input logic [31:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    load_start_index(value);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // fresh buffer: last code and size are zero, so a zero event repeats
  task automatic test_fresh_buffer();
    write_start_index(32'h0000_0000);
    send_event(make_event(buf_index, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 1'b1));
    send_event(make_event(buf_index, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 1'b0));
    // every index bit flipped
    send_event(make_event(~buf_index, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 1'b0));
  endtask

  // full and short headers, exact and truncated deltas, longest values
  task automatic test_header_forms();
    send_event(make_event(buf_index, 16'hffff, 16'h0000, last_stamp + 32'd5, 1'b0, 1'b0));
    // 34-bit short value, five bytes
    send_event(make_event(buf_index, 16'hffff, 16'h0000, last_stamp + 32'hffff_ffff,
                          1'b0, 1'b0));
    send_event(make_event(buf_index, 16'hffff, 16'h0000, last_stamp + 32'h4000_2000,
                          1'b0, 1'b0));
    send_event(make_event(buf_index, 16'h1234, 16'd700, last_stamp + 32'h2000_0000,
                          1'b0, 1'b0));
  endtask

  // coarsening kept off when it would step back, forced on otherwise
  task automatic test_coarse_time();
    send_event(make_event(buf_index, 16'h0005, 16'd10, 32'h1234_5001, 1'b0, 1'b0));
    send_event(make_event(buf_index, 16'h0006, 16'd10, 32'h1234_5fff, 1'b1, 1'b0));
    send_event(make_event(buf_index, 16'h0006, 16'd10, 32'h9abc_def1, 1'b1, 1'b0));
    send_event(make_event(buf_index, 16'h0007, 16'd11, 32'h9abc_f123, 1'b1, 1'b0));
  endtask

  // oversized payloads, including the largest field value
  task automatic test_too_large();
    send_event(make_event(buf_index, 16'h0100, 16'hffff, last_stamp + 32'd1, 1'b0, 1'b0));
    send_event(make_event(buf_index, 16'h0101, 16'(BUF_BYTES - 8), last_stamp + 32'd1,
                          1'b0, 1'b0));
  endtask

  // buffer full from the top index: wraps to zero, stale index then rejected
  task automatic test_rollover();
    write_start_index(32'hffff_ffff);
    send_event(make_event(buf_index, 16'h0200, 16'd4000, 32'h0000_0100, 1'b0, 1'b0));
    send_event(make_event(buf_index, 16'h0201, 16'd4000, 32'h0000_0200, 1'b0, 1'b0));
    send_event(make_event(32'hffff_ffff, 16'h0202, 16'd4, 32'h0000_0300, 1'b0, 1'b0));
    send_event(make_event(buf_index, 16'h0202, 16'd4, 32'h0000_0300, 1'b0, 1'b0));
  endtask

  // output held off for a long stretch while events keep coming
  task automatic test_output_holdoff();
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    repeat (8) send_event(random_event());
  endtask

  task automatic test_random_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                                   input logic [31:0] start_value, input int unsigned count);
    write_start_index(start_value);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (count) send_event(random_event());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fresh_buffer();
    test_header_forms();
    test_coarse_time();
    test_too_large();
    test_rollover();
    test_output_holdoff();
    test_random_phase(20, 68, $urandom(), 42);
    test_random_phase(68, 20, 32'hffff_fffe, 42);
    test_random_phase(0, 0, $urandom(), 42);

    drain_results();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
